@@ design/dbeh_pkg.sv @@
// shared types and constants for the depth binned energy histogram
package dbeh_pkg;

   // field widths fixed by the interface
   localparam int DEPTH_W  = 31;
   localparam int ENERGY_W = 32;
   localparam int BW_W     = 30;
   localparam int NBINS_W  = 9;
   localparam int RIDX_W   = 8;
   localparam int OSUM_W   = 48;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // quotient bits needed to compare against any bin count, plus one overflow bit
   localparam int QW     = NBINS_W;
   localparam int DIV_W  = BW_W + QW;
   localparam int CNT_W  = $clog2(QW + 1);

   // register reset values
   localparam logic signed [DEPTH_W-1:0] Z_MIN_RST     = -31'sd150000;
   localparam logic signed [DEPTH_W-1:0] Z_MAX_RST     = 31'sd150000;
   localparam logic [BW_W-1:0]           BIN_WIDTH_RST = 30'd2000;
   localparam logic [NBINS_W-1:0]        NUM_BINS_RST  = 9'd150;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MIN     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MAX     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS  = 4'd3;

   // request action codes
   localparam logic [1:0] ACT_DEPOSIT = 2'd0;
   localparam logic [1:0] ACT_CLEAR   = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_RD    = 7'b0010000,
      ST_MOD   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

endpackage

@@ design/dbeh_ram.sv @@
// generic single write, single read ram with registered read data
module dbeh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/depth_binned_energy_histogram.sv @@
// weighted depth histogram: bins deposits by depth and accumulates saturating energy sums
// a deposit goes from request transfer through check, the radix-2 bin divider, ram read,
// modify and finish to result valid; a read skips the divider; a clear runs check, a
// clearing pass with one ram write per bin, then finish; one request in flight at a time;
// the next request is taken once the result sits in the output register
// after reset a clearing pass zeroes every bin of the ram before any request is taken
module depth_binned_energy_histogram #(
   parameter int MAX_BINS  = 256,
   parameter int SUM_WIDTH = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_action,
   input  logic signed [dbeh_pkg::DEPTH_W-1:0]  req_depth,
   input  logic [dbeh_pkg::ENERGY_W-1:0]        req_energy,
   input  logic [dbeh_pkg::RIDX_W-1:0]          req_read_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [dbeh_pkg::RIDX_W-1:0]          rsp_bin_index,
   output logic [dbeh_pkg::OSUM_W-1:0]          rsp_bin_sum,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbeh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dbeh_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int QW = dbeh_pkg::QW;
   localparam int DEPTH_W = dbeh_pkg::DEPTH_W;
   localparam int DIV_W = dbeh_pkg::DIV_W;

   // configuration registers
   logic signed [DEPTH_W-1:0]          z_min_ff;
   logic signed [DEPTH_W-1:0]          z_max_ff;
   logic [dbeh_pkg::BW_W-1:0]          bin_width_ff;
   logic [dbeh_pkg::NBINS_W-1:0]       num_bins_ff;

   // control
   dbeh_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                      clr_ff, clr_in;
   logic                               clr_rsp_ff, clr_rsp_in;
   logic [dbeh_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // request and working registers
   logic [1:0]                         act_ff, act_in;
   logic signed [DEPTH_W-1:0]          depth_ff, depth_in;
   logic [dbeh_pkg::ENERGY_W-1:0]      energy_ff, energy_in;
   logic [dbeh_pkg::RIDX_W-1:0]        ridx_ff, ridx_in;
   logic [DEPTH_W-1:0]                 rem_ff, rem_in;
   logic [DIV_W-1:0]                   div_ff, div_in;
   logic [QW:0]                        q_ff, q_in;
   logic [AW-1:0]                      addr_ff, addr_in;

   // pending result and output registers
   logic                               res_acc_ff, res_acc_in;
   logic [dbeh_pkg::RIDX_W-1:0]        res_idx_ff, res_idx_in;
   logic [dbeh_pkg::OSUM_W-1:0]        res_sum_ff, res_sum_in;
   logic                               res_sat_ff, res_sat_in;
   logic                               rsp_acc_ff, rsp_acc_in;
   logic [dbeh_pkg::RIDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [dbeh_pkg::OSUM_W-1:0]        rsp_sum_ff, rsp_sum_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   // ram port
   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_wr_addr;
   logic [SUM_WIDTH-1:0]               ram_wr_data;
   logic                               ram_rd_en;
   logic [SUM_WIDTH-1:0]               ram_rd_data;

   // datapath helpers
   logic signed [DEPTH_W:0]            diff_full;
   logic [DIV_W-1:0]                   rem_wide;
   logic [DIV_W-1:0]                   rem_sub;
   logic                               div_ge;
   logic [QW-1:0]                      q_lo;
   logic [QW-1:0]                      q_next_lo;
   logic [AW+QW-1:0]                   q_next_wide;
   logic [AW+dbeh_pkg::RIDX_W-1:0]     ridx_wide;
   logic [AW+dbeh_pkg::RIDX_W-1:0]     addr_wide;
   logic                               bin_ok;
   logic                               rd_in_store;
   logic                               dep_reject;
   logic [SUM_WIDTH:0]                 sum_calc;
   logic                               sum_sat;
   logic [SUM_WIDTH-1:0]               sum_new;
   logic [SUM_WIDTH+dbeh_pkg::OSUM_W-1:0] sum_new_wide;
   logic [SUM_WIDTH+dbeh_pkg::OSUM_W-1:0] rd_data_wide;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != dbeh_pkg::ST_IDLE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_acc_ff;
   assign rsp_bin_index = rsp_idx_ff;
   assign rsp_bin_sum   = rsp_sum_ff;
   assign rsp_saturated = rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_min_ff     <= dbeh_pkg::Z_MIN_RST;
         z_max_ff     <= dbeh_pkg::Z_MAX_RST;
         bin_width_ff <= dbeh_pkg::BIN_WIDTH_RST;
         num_bins_ff  <= dbeh_pkg::NUM_BINS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dbeh_pkg::CSR_Z_MIN:     z_min_ff     <= csr_data[DEPTH_W-1:0];
            dbeh_pkg::CSR_Z_MAX:     z_max_ff     <= csr_data[DEPTH_W-1:0];
            dbeh_pkg::CSR_BIN_WIDTH: bin_width_ff <= csr_data[dbeh_pkg::BW_W-1:0];
            dbeh_pkg::CSR_NUM_BINS:  num_bins_ff  <= csr_data[dbeh_pkg::NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   // range checks and offset into the histogram
   assign diff_full  = {depth_ff[DEPTH_W-1], depth_ff} - {z_min_ff[DEPTH_W-1], z_min_ff};
   assign dep_reject = (energy_ff == '0) || (bin_width_ff == '0) ||
                       (depth_ff < z_min_ff) || (depth_ff >= z_max_ff);

   // one restoring division step per cycle, divisor shifted right each step
   assign rem_wide  = {{(DIV_W-DEPTH_W){1'b0}}, rem_ff};
   assign div_ge    = (rem_wide >= div_ff);
   assign rem_sub   = rem_wide - div_ff;
   assign q_next_lo = {q_ff[QW-2:0], div_ge};
   assign q_next_wide = {{AW{1'b0}}, q_next_lo};

   assign q_lo   = q_ff[QW-1:0];
   assign bin_ok = !q_ff[QW] && (q_lo < num_bins_ff) && (32'(q_lo) < 32'(MAX_BINS));

   assign ridx_wide   = {{AW{1'b0}}, ridx_ff};
   assign rd_in_store = (32'(ridx_ff) < 32'(MAX_BINS));
   assign addr_wide   = {{dbeh_pkg::RIDX_W{1'b0}}, addr_ff};

   // saturating accumulate
   assign sum_calc = {1'b0, ram_rd_data} +
                     {{(SUM_WIDTH+1-dbeh_pkg::ENERGY_W){1'b0}}, energy_ff};
   assign sum_sat  = sum_calc[SUM_WIDTH];
   assign sum_new  = sum_sat ? {SUM_WIDTH{1'b1}} : sum_calc[SUM_WIDTH-1:0];
   assign sum_new_wide = {{dbeh_pkg::OSUM_W{1'b0}}, sum_new};
   assign rd_data_wide = {{dbeh_pkg::OSUM_W{1'b0}}, ram_rd_data};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      act_in       = act_ff;
      depth_in     = depth_ff;
      energy_in    = energy_ff;
      ridx_in      = ridx_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      q_in         = q_ff;
      addr_in      = addr_ff;
      res_acc_in   = res_acc_ff;
      res_idx_in   = res_idx_ff;
      res_sum_in   = res_sum_ff;
      res_sat_in   = res_sat_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = sum_new;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         dbeh_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_BINS - 1)) begin
               clr_in = '0;
               if (clr_rsp_ff) begin
                  res_acc_in = 1'b1;
                  res_idx_in = '0;
                  res_sum_in = '0;
                  res_sat_in = 1'b0;
                  state_in   = dbeh_pkg::ST_FIN;
               end else begin
                  state_in = dbeh_pkg::ST_IDLE;
               end
            end
         end
         dbeh_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               depth_in  = req_depth;
               energy_in = req_energy;
               ridx_in   = req_read_index;
               state_in  = dbeh_pkg::ST_CHECK;
            end
         end
         dbeh_pkg::ST_CHECK: begin
            res_acc_in = 1'b0;
            res_idx_in = '0;
            res_sum_in = '0;
            res_sat_in = 1'b0;
            unique case (act_ff)
               dbeh_pkg::ACT_DEPOSIT: begin
                  if (dep_reject) begin
                     state_in = dbeh_pkg::ST_FIN;
                  end else begin
                     rem_in   = diff_full[DEPTH_W-1:0];
                     div_in   = {bin_width_ff, {QW{1'b0}}};
                     q_in     = '0;
                     cnt_in   = dbeh_pkg::CNT_W'(QW);
                     state_in = dbeh_pkg::ST_DIV;
                  end
               end
               dbeh_pkg::ACT_CLEAR: begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = dbeh_pkg::ST_CLEAR;
               end
               dbeh_pkg::ACT_READ: begin
                  if (rd_in_store) begin
                     addr_in  = ridx_wide[AW-1:0];
                     state_in = dbeh_pkg::ST_RD;
                  end else begin
                     state_in = dbeh_pkg::ST_FIN;
                  end
               end
               default: state_in = dbeh_pkg::ST_FIN;
            endcase
         end
         dbeh_pkg::ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_sub[DEPTH_W-1:0];
            end
            div_in = div_ff >> 1;
            q_in   = {q_ff[QW-1:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               addr_in  = q_next_wide[AW-1:0];
               state_in = dbeh_pkg::ST_RD;
            end
         end
         dbeh_pkg::ST_RD: begin
            // reads always use addr_ff; a deposit past the bin limit gives up here
            if ((act_ff == dbeh_pkg::ACT_READ) || bin_ok) begin
               ram_rd_en = 1'b1;
               state_in  = dbeh_pkg::ST_MOD;
            end else begin
               state_in = dbeh_pkg::ST_FIN;
            end
         end
         dbeh_pkg::ST_MOD: begin
            res_acc_in = 1'b1;
            res_idx_in = addr_wide[dbeh_pkg::RIDX_W-1:0];
            if (act_ff == dbeh_pkg::ACT_READ) begin
               res_sum_in = rd_data_wide[dbeh_pkg::OSUM_W-1:0];
               res_sat_in = 1'b0;
            end else begin
               ram_wr_en  = 1'b1;
               res_sum_in = sum_new_wide[dbeh_pkg::OSUM_W-1:0];
               res_sat_in = sum_sat;
            end
            state_in = dbeh_pkg::ST_FIN;
         end
         dbeh_pkg::ST_FIN: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_sum_in   = res_sum_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = dbeh_pkg::ST_IDLE;
            end
         end
         default: state_in = dbeh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbeh_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      depth_ff   <= depth_in;
      energy_ff  <= energy_in;
      ridx_ff    <= ridx_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      q_ff       <= q_in;
      addr_ff    <= addr_in;
      res_acc_ff <= res_acc_in;
      res_idx_ff <= res_idx_in;
      res_sum_ff <= res_sum_in;
      res_sat_ff <= res_sat_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   dbeh_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

endmodule
